// File: hw/rtl/tcd_pkg.sv
// Package for the tagged chunk deframer: payload structs, status codes and
// header geometry constants. No dependencies.
`default_nettype none
package tcd_pkg;

	localparam int unsigned HdrLen  = 8;
	localparam int unsigned TagLen  = 4;
	localparam int unsigned TagW    = 8 * TagLen;
	localparam int unsigned LenW    = 8 * (HdrLen - TagLen);
	localparam int unsigned HdrCntW = $clog2(HdrLen);

	localparam logic [1:0] StPayload = 2'd0;
	localparam logic [1:0] StBadTag  = 2'd1;
	localparam logic [1:0] StEnd     = 2'd2;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       stream_end;
	} in_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [1:0] status;
	} out_t;

	typedef struct packed {
		logic            done;
		logic            tag_ok;
		logic            len_zero;
		logic [LenW-1:0] len;
	} hdr_info_t;

endpackage
`default_nettype wire

// File: hw/rtl/tcd_hdr.sv
// Chunk header collector: gathers header bytes and checks the tag on the last one.
// Depends on tcd_pkg.
`default_nettype none
module tcd_hdr (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire logic                    clear,
	input  wire logic [7:0]              data,
	input  wire logic [tcd_pkg::TagW-1:0] expected_tag,
	output tcd_pkg::hdr_info_t           info
);

	localparam logic [tcd_pkg::HdrCntW-1:0] CntLast =
		tcd_pkg::HdrCntW'(tcd_pkg::HdrLen - 1);

	logic [tcd_pkg::HdrCntW-1:0] cnt_q;
	logic [tcd_pkg::HdrLen-1:0][7:0] bytes_q;
	logic [tcd_pkg::TagW-1:0] tag;
	logic [tcd_pkg::LenW-1:0] len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clear) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= (cnt_q == CntLast) ? '0 : cnt_q + tcd_pkg::HdrCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			bytes_q[cnt_q] <= data;
		end
	end

	always_comb begin
		for (int i = 0; i < tcd_pkg::TagLen; i++) begin
			tag[8*i +: 8] = bytes_q[i];
		end
		for (int i = 0; i < tcd_pkg::HdrLen - tcd_pkg::TagLen - 1; i++) begin
			len[8*i +: 8] = bytes_q[tcd_pkg::TagLen + i];
		end
		len[tcd_pkg::LenW-8 +: 8] = data;
		info.done     = push && (cnt_q == CntLast);
		info.tag_ok   = (tag == expected_tag);
		info.len_zero = (len == '0);
		info.len      = len;
	end

endmodule
`default_nettype wire

// File: hw/rtl/tagged_chunk_deframer.sv
// Top level of the tagged chunk deframer: mode control, payload counter and
// output register. Depends on tcd_pkg and tcd_hdr.
// Takes one stream byte per clock and strips 8-byte chunk headers (32-bit tag,
// 32-bit length, little endian), passing only payload bytes. Each payload byte
// and each status is registered into a single output register; in_ready
// is high whenever that register is empty or being drained, so the sustained
// rate is one byte per cycle with out_ready held high. A header tag that does
// not match the configured value reports a bad-tag status once and the block
// then drops everything until reset. An end mark reports end of stream.
`default_nettype none
module tagged_chunk_deframer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tcd_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output tcd_pkg::out_t      out_data,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [31:0]   cfg_data
);

	typedef enum logic [1:0] {
		MODE_HEADER,
		MODE_PAYLOAD,
		MODE_ERROR,
		MODE_ENDED
	} mode_t;

	mode_t                    mode_q;
	logic [tcd_pkg::LenW-1:0] payload_left_q;
	logic [tcd_pkg::TagW-1:0] expected_tag_q;
	logic                     out_valid_q;
	tcd_pkg::out_t            out_q;

	logic               in_fire;
	logic               out_load;
	logic               hdr_push;
	logic               hdr_clear;
	tcd_pkg::hdr_info_t hdr_info;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign hdr_push  = in_fire && !in_data.stream_end && (mode_q == MODE_HEADER);
	assign hdr_clear = in_fire && in_data.stream_end &&
		((mode_q == MODE_HEADER) || (mode_q == MODE_PAYLOAD));

	tcd_hdr u_hdr (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (hdr_push),
		.clear        (hdr_clear),
		.data         (in_data.byte_in),
		.expected_tag (expected_tag_q),
		.info         (hdr_info)
	);

	always_comb begin
		out_load = 1'b0;
		if (in_fire) begin
			case (mode_q)
				MODE_ERROR:   out_load = 1'b0;
				MODE_ENDED:   out_load = in_data.stream_end;
				MODE_PAYLOAD: out_load = 1'b1;
				default:      out_load = in_data.stream_end ||
					(hdr_info.done && !hdr_info.tag_ok);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_tag_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			expected_tag_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_HEADER;
			payload_left_q <= '0;
			out_valid_q    <= 1'b0;
			out_q          <= '0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			if (in_fire) begin
				case (mode_q)
					MODE_ERROR: begin
					end
					MODE_ENDED: begin
						if (in_data.stream_end) begin
							out_q <= '{payload_byte: 8'd0, status: tcd_pkg::StEnd};
						end
					end
					MODE_PAYLOAD: begin
						if (in_data.stream_end) begin
							mode_q         <= MODE_ENDED;
							payload_left_q <= '0;
							out_q          <= '{payload_byte: 8'd0, status: tcd_pkg::StEnd};
						end else begin
							payload_left_q <= payload_left_q - tcd_pkg::LenW'(1);
							if (payload_left_q == tcd_pkg::LenW'(1)) begin
								mode_q <= MODE_HEADER;
							end
							out_q <= '{payload_byte: in_data.byte_in,
								status: tcd_pkg::StPayload};
						end
					end
					default: begin
						if (in_data.stream_end) begin
							mode_q         <= MODE_ENDED;
							payload_left_q <= '0;
							out_q          <= '{payload_byte: 8'd0, status: tcd_pkg::StEnd};
						end else if (hdr_info.done) begin
							if (!hdr_info.tag_ok) begin
								mode_q <= MODE_ERROR;
								out_q  <= '{payload_byte: 8'd0,
									status: tcd_pkg::StBadTag};
							end else begin
								payload_left_q <= hdr_info.len;
								mode_q <= hdr_info.len_zero ? MODE_HEADER : MODE_PAYLOAD;
							end
						end
					end
				endcase
			end
		end
	end

`ifndef ASSERT_OFF
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ERROR |=> mode_q == MODE_ERROR)
		else $error("error mode left without reset");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_PAYLOAD |-> payload_left_q != '0)
		else $error("payload mode with zero bytes left");

	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status != tcd_pkg::StPayload) |-> out_q.payload_byte == 8'd0)
		else $error("nonzero byte on a status transaction");

	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (mode_q == MODE_ERROR) && !out_valid_q |=> !out_valid_q)
		else $error("transaction produced in error mode");
`endif

endmodule
`default_nettype wire

// File: tb/tcd_stream_checker.sv
// Scoreboard for the tagged chunk deframer: watches the input, output and tag
// register channels, predicts each result and compares it with the block's.
// Depends on tcd_pkg.
module tcd_stream_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_ready,
	input  tcd_pkg::in_t       in_data,
	input  wire logic          out_valid,
	input  wire logic          out_ready,
	input  tcd_pkg::out_t      out_data,
	input  wire logic          cfg_valid,
	input  wire logic          cfg_ready,
	input  wire logic [31:0]   cfg_data,
	output int                 fail_count,
	output int                 pending
);

	typedef enum logic [1:0] {
		DF_HEADER,
		DF_PAYLOAD,
		DF_ERROR,
		DF_ENDED
	} df_mode_t;

	logic [31:0]   tag_cfg;
	logic [63:0]   hdr_bytes;
	logic [3:0]    hdr_cnt;
	logic [31:0]   bytes_left;
	df_mode_t      mode;
	tcd_pkg::out_t results_due[$];

	function automatic bit deframe_step(input tcd_pkg::in_t item, output tcd_pkg::out_t res);
		logic [31:0] tag_seen;
		logic [31:0] len_seen;
		res = '0;
		if (mode == DF_ERROR)
			return 1'b0;
		if (mode == DF_ENDED) begin
			res.status = tcd_pkg::StEnd;
			return item.stream_end;
		end
		if (item.stream_end) begin
			mode = DF_ENDED;
			hdr_bytes = '0;
			hdr_cnt = '0;
			bytes_left = '0;
			res.status = tcd_pkg::StEnd;
			return 1'b1;
		end
		if (mode == DF_PAYLOAD) begin
			bytes_left = bytes_left - 32'd1;
			if (bytes_left == '0)
				mode = DF_HEADER;
			res.payload_byte = item.byte_in;
			res.status = tcd_pkg::StPayload;
			return 1'b1;
		end
		hdr_bytes = hdr_bytes | (64'(item.byte_in) << (8 * hdr_cnt[2:0]));
		hdr_cnt = hdr_cnt + 4'd1;
		if (hdr_cnt < tcd_pkg::HdrLen)
			return 1'b0;
		tag_seen = hdr_bytes[tcd_pkg::TagW-1:0];
		len_seen = hdr_bytes[tcd_pkg::TagW +: tcd_pkg::LenW];
		hdr_bytes = '0;
		hdr_cnt = '0;
		if (tag_seen != tag_cfg) begin
			mode = DF_ERROR;
			res.status = tcd_pkg::StBadTag;
			return 1'b1;
		end
		bytes_left = len_seen;
		mode = (len_seen != '0) ? DF_PAYLOAD : DF_HEADER;
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tcd_pkg::out_t predicted;
		tcd_pkg::out_t oldest;
		if (!arst_n) begin
			tag_cfg = '0;
			hdr_bytes = '0;
			hdr_cnt = '0;
			bytes_left = '0;
			mode = DF_HEADER;
			results_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				tag_cfg = cfg_data;
			if (in_valid && in_ready) begin
				if (deframe_step(in_data, predicted))
					results_due.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result: byte %02h status %0d", $time,
							out_data.payload_byte, out_data.status);
				end else begin
					oldest = results_due.pop_front();
					if (out_data.payload_byte !== oldest.payload_byte ||
						out_data.status !== oldest.status) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: expected %02h/%0d, got %02h/%0d",
								$time, oldest.payload_byte, oldest.status,
								out_data.payload_byte, out_data.status);
					end
				end
			end
			pending = results_due.size();
		end
	end

endmodule

// File: tb/tb_tagged_chunk_deframer.sv
// Top of the tagged chunk deframer testbench: clock, reset, chunk stream and
// tag register stimulus, watchdog and verdict. Depends on tcd_pkg,
// tagged_chunk_deframer and tcd_stream_checker.
module tb_tagged_chunk_deframer;

	localparam int QuietLimit = 5000;

	typedef enum int {
		PACE_FREE,
		PACE_SEND_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH
	} pace_t;

	typedef enum int {
		END_BAD_TAG,
		END_AT_BOUNDARY,
		END_IN_HEADER,
		END_IN_PAYLOAD
	} ending_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	tcd_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	tcd_pkg::out_t out_data;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [31:0]   cfg_data = '0;
	logic [31:0]   phase_tag = '0;
	int            idle_pct = 0;
	int            stall_pct = 0;
	int            quiet_cycles = 0;
	int            fail_count;
	int            pending;

	always #5 clk = ~clk;

	tagged_chunk_deframer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	tcd_stream_checker stream_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= QuietLimit) begin
				$display("FAIL");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_pace(input pace_t pace);
		case (pace)
			PACE_FREE: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			PACE_SEND_IDLE: begin
				idle_pct = 57;
				stall_pct = 0;
			end
			PACE_RECV_STALL: begin
				idle_pct = 0;
				stall_pct = 57;
			end
			default: begin
				idle_pct = 32;
				stall_pct = 32;
			end
		endcase
	endtask

	task automatic push_item(input logic [7:0] b, input logic ends);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= tcd_pkg::in_t'{byte_in: b, stream_end: ends};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_header(input logic [31:0] tag, input logic [31:0] len, input int count);
		logic [63:0] hdr;
		hdr = {len, tag};
		for (int i = 0; i < count; i++)
			push_item(hdr[8*i +: 8], 1'b0);
	endtask

	task automatic send_chunk(input logic [31:0] len);
		send_header(phase_tag, len, tcd_pkg::HdrLen);
		repeat (len)
			push_item(8'($urandom_range(255)), 1'b0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic retag(input logic [31:0] value);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		phase_tag = value;
	endtask

	initial begin
		logic [31:0] len;
		int          bytes_done;
		int          pick;
		ending_t     ending;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_pace(PACE_FREE);
		send_header(phase_tag, 32'd0, tcd_pkg::HdrLen);
		send_header(phase_tag, 32'd2, tcd_pkg::HdrLen);
		push_item(8'h00, 1'b0);
		push_item(8'hFF, 1'b0);
		retag(32'hFFFF_FFFF);
		send_header(phase_tag, 32'd1, tcd_pkg::HdrLen);
		push_item(8'h81, 1'b0);

		for (int p = 0; p < 8; p++) begin
			retag((p == 3) ? 32'h0 : $urandom());
			set_pace(pace_t'(p % 4));
			bytes_done = 0;
			while (bytes_done < 250) begin
				pick = $urandom_range(99);
				if (pick < 15)
					len = 0;
				else if (pick < 85)
					len = $urandom_range(16, 1);
				else
					len = $urandom_range(80, 17);
				send_chunk(len);
				bytes_done += tcd_pkg::HdrLen + len;
			end
		end

		set_pace(PACE_BOTH);
		ending = ending_t'($urandom_range(3));
		case (ending)
			END_BAD_TAG:
				send_header(phase_tag ^ (32'd1 << $urandom_range(31)), 32'hFFFF_FFFF,
					tcd_pkg::HdrLen);
			END_AT_BOUNDARY:
				push_item(8'($urandom_range(255)), 1'b1);
			END_IN_HEADER: begin
				send_header(phase_tag, 32'hFFFF_FFFF, $urandom_range(tcd_pkg::HdrLen - 1, 1));
				push_item(8'($urandom_range(255)), 1'b1);
			end
			default: begin
				send_header(phase_tag, 32'hFFFF_FFFF, tcd_pkg::HdrLen);
				repeat ($urandom_range(20, 1))
					push_item(8'($urandom_range(255)), 1'b0);
				push_item(8'($urandom_range(255)), 1'b1);
			end
		endcase
		repeat (40)
			push_item(8'($urandom_range(255)), $urandom_range(99) < 30);

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
